FILE: rtl/qrus_pkg.sv
// Shared types, constants and codes for the QR module upscale scan-out block.
`timescale 1ns / 1ps

package qrus_pkg;

  // Symbol and canvas limits
  localparam int MaxModules = 177;
  localparam int MaxCanvas  = 512;
  localparam int WordBits   = 32;
  localparam int RowWords   = (MaxModules + WordBits - 1) / WordBits;
  localparam int StoreDepth = MaxModules * RowWords;

  // Derived widths
  localparam int AddrW    = $clog2(StoreDepth);
  localparam int BitW     = $clog2(WordBits);
  localparam int CanvasW  = $clog2(MaxCanvas + 1);     // holds the canvas size itself
  localparam int PosW     = $clog2(MaxCanvas);         // pixel position on one axis
  localparam int ByteW    = $clog2(MaxCanvas / 8);     // byte column
  localparam int StrideW  = $clog2(MaxCanvas / 8 + 1); // bytes per row, inclusive
  localparam int ScaleW   = 10;
  localparam int ModW     = 8;
  localparam int ProdW    = ModW + ScaleW;
  localparam int RxW      = PosW + 1;
  localparam int ColW     = RxW + 1;
  localparam int CntW     = $clog2(PosW + 1);

  // Register file
  localparam int NumRegs  = 8;
  localparam int RegAddrW = $clog2(NumRegs * 4);
  localparam int IdxW     = $clog2(NumRegs);

  localparam logic [ModW-1:0]   RstRegionX0 = 8'd0;
  localparam logic [ModW-1:0]   RstRegionY0 = 8'd0;
  localparam logic [ModW-1:0]   RstRegionW  = 8'd21;
  localparam logic [ModW-1:0]   RstRegionH  = 8'd21;
  localparam logic [ScaleW-1:0] RstScale    = 10'd1;
  localparam logic [ModW-1:0]   RstCells    = 8'd21;
  localparam logic [9:0]        RstCanvas   = 10'd256;
  localparam logic [ModW-1:0]   RstSymbol   = 8'd21;

  typedef enum logic [IdxW-1:0] {
    REG_REGION_X0  = 3'd0,
    REG_REGION_Y0  = 3'd1,
    REG_REGION_W   = 3'd2,
    REG_REGION_H   = 3'd3,
    REG_PIXEL_SCALE = 3'd4,
    REG_CELL_COUNT = 3'd5,
    REG_CANVAS     = 3'd6,
    REG_SYMBOL     = 3'd7
  } reg_idx_e;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_MARGIN,
    ST_ROW_LOAD,
    ST_ROW_DIV,
    ST_COL_LOAD,
    ST_COL_DIV,
    ST_COL_INIT,
    ST_PIXEL,
    ST_DRAIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [ModW-1:0]   region_x0;
    logic [ModW-1:0]   region_y0;
    logic [ModW-1:0]   region_w;
    logic [ModW-1:0]   region_h;
    logic [ScaleW-1:0] pixel_scale;
    logic [ModW-1:0]   cell_count;
    logic [9:0]        canvas_pixels;
    logic [ModW-1:0]   symbol_size;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       mem_we;      // store the input word
    logic       start;       // clear byte, register canvas, stride, product
    logic       margin_en;   // register the margin
    logic       div_load;    // load divider
    logic       div_col;     // divider dividend: 0 row, 1 column
    logic       div_step;    // one restoring division step
    logic       row_capture; // take row quotient
    logic       col_capture; // take column quotient and remainder
    logic       pix_step;    // evaluate one pixel
    logic [2:0] pix_idx;     // pixel within the byte, 0 leftmost
    logic       out_load;    // move byte to output register, advance scan
  } cmd_t;

endpackage

FILE: rtl/qrus_regs.sv
// APB configuration register file.
`timescale 1ns / 1ps

module qrus_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qrus_pkg::RegAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output qrus_pkg::cfg_t                cfg_o
);
  import qrus_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[RegAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_x0     <= RstRegionX0;
      cfg_q.region_y0     <= RstRegionY0;
      cfg_q.region_w      <= RstRegionW;
      cfg_q.region_h      <= RstRegionH;
      cfg_q.pixel_scale   <= RstScale;
      cfg_q.cell_count    <= RstCells;
      cfg_q.canvas_pixels <= RstCanvas;
      cfg_q.symbol_size   <= RstSymbol;
    end else if (wr_en) begin
      unique case (idx)
        REG_REGION_X0:   cfg_q.region_x0     <= pwdata[ModW-1:0];
        REG_REGION_Y0:   cfg_q.region_y0     <= pwdata[ModW-1:0];
        REG_REGION_W:    cfg_q.region_w      <= pwdata[ModW-1:0];
        REG_REGION_H:    cfg_q.region_h      <= pwdata[ModW-1:0];
        REG_PIXEL_SCALE: cfg_q.pixel_scale   <= pwdata[ScaleW-1:0];
        REG_CELL_COUNT:  cfg_q.cell_count    <= pwdata[ModW-1:0];
        REG_CANVAS:      cfg_q.canvas_pixels <= pwdata[9:0];
        REG_SYMBOL:      cfg_q.symbol_size   <= pwdata[ModW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_REGION_X0:   prdata = 32'(cfg_q.region_x0);
      REG_REGION_Y0:   prdata = 32'(cfg_q.region_y0);
      REG_REGION_W:    prdata = 32'(cfg_q.region_w);
      REG_REGION_H:    prdata = 32'(cfg_q.region_h);
      REG_PIXEL_SCALE: prdata = 32'(cfg_q.pixel_scale);
      REG_CELL_COUNT:  prdata = 32'(cfg_q.cell_count);
      REG_CANVAS:      prdata = 32'(cfg_q.canvas_pixels);
      REG_SYMBOL:      prdata = 32'(cfg_q.symbol_size);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/qrus_ctrl.sv
// Sequencing state machine: input handshake, division and pixel steps, output register.
`timescale 1ns / 1ps

module qrus_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           opcode_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output qrus_pkg::cmd_t cmd_o
);
  import qrus_pkg::*;

  localparam logic [CntW-1:0] DivLast = CntW'(PosW - 1);
  localparam logic [CntW-1:0] PixLast = CntW'(7);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = '0;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.pix_idx = cnt_q[2:0];

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (opcode_i == OP_EMIT) begin
            cmd_o.start = 1'b1;
            state_d     = ST_PROD;
          end else begin
            cmd_o.mem_we = 1'b1;
          end
        end
      end
      ST_PROD: begin
        state_d = ST_MARGIN;
      end
      ST_MARGIN: begin
        cmd_o.margin_en = 1'b1;
        state_d         = ST_ROW_LOAD;
      end
      ST_ROW_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_ROW_DIV;
      end
      ST_ROW_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          cnt_d   = '0;
          state_d = ST_COL_LOAD;
        end
      end
      ST_COL_LOAD: begin
        cmd_o.row_capture = 1'b1;
        cmd_o.div_load    = 1'b1;
        cmd_o.div_col     = 1'b1;
        state_d           = ST_COL_DIV;
      end
      ST_COL_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          cnt_d   = '0;
          state_d = ST_COL_INIT;
        end
      end
      ST_COL_INIT: begin
        cmd_o.col_capture = 1'b1;
        state_d           = ST_PIXEL;
      end
      ST_PIXEL: begin
        cmd_o.pix_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == PixLast) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/qrus_dp.sv
// Datapath: module store, margin, shared divider, pixel walk, scan position, output word.
`timescale 1ns / 1ps

module qrus_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  qrus_pkg::cmd_t            cmd_i,
  input  qrus_pkg::cfg_t            cfg_i,
  input  logic [7:0]                module_row_i,
  input  logic [2:0]                word_index_i,
  input  logic [31:0]               module_bits_i,
  output logic [7:0]                pixel_byte_o,
  output logic [8:0]                canvas_row_o,
  output logic [5:0]                byte_column_o,
  output logic                      frame_end_o
);
  import qrus_pkg::*;

  // Module store
  logic [WordBits-1:0] mem_q [StoreDepth];
  logic [WordBits-1:0] rd_q;
  logic [AddrW-1:0]    waddr, raddr;
  logic                wr_ok;

  // Frame geometry
  logic [CanvasW-1:0] canvas, canvas_q;
  logic [StrideW-1:0] stride_q;
  logic [ProdW-1:0]   prod_q;
  logic [PosW-1:0]    margin_q;
  logic [CanvasW-1:0] diff;

  // Divider
  logic [ScaleW-1:0]  div_rem_q;
  logic [PosW-1:0]    div_quo_q;
  logic [ScaleW:0]    div_trial;
  logic               div_take;
  logic [PosW-1:0]    row_rel, col_rel, x0;

  // Row and pixel walk
  logic               row_in_q;
  logic [PosW-1:0]    mrow_q;
  logic [ModW-1:0]    row_module;
  logic               row_ok;
  logic [RxW-1:0]     rx_q;
  logic [ScaleW-1:0]  rem_q;
  logic [PosW-1:0]    px_x;
  logic [ColW-1:0]    col;
  logic               x_ge_m, px_ok;
  logic               p_valid_q;
  logic [BitW-1:0]    p_bit_q;
  logic [2:0]         p_pos_q;
  logic [7:0]         bits_q;

  // Scan position and output word
  logic [PosW-1:0]    scan_row_q;
  logic [ByteW-1:0]   scan_byte_q;
  logic               row_last, byte_last;
  logic [7:0]         pixel_byte_q;
  logic [PosW-1:0]    canvas_row_q;
  logic [ByteW-1:0]   byte_column_q;
  logic               frame_end_q;

  // ---- store write and read ----
  assign wr_ok = (module_row_i < ModW'(MaxModules)) && (word_index_i < 3'(RowWords));
  assign waddr = AddrW'(module_row_i) * AddrW'(RowWords) + AddrW'(word_index_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we && wr_ok) begin
      mem_q[waddr] <= module_bits_i;
    end
    if (cmd_i.pix_step) begin
      rd_q <= mem_q[raddr];
    end
  end

  // ---- geometry ----
  always_comb begin
    canvas = cfg_i.canvas_pixels;
    if (cfg_i.canvas_pixels == '0) begin
      canvas = CanvasW'(1);
    end else if (cfg_i.canvas_pixels > 10'(MaxCanvas)) begin
      canvas = CanvasW'(MaxCanvas);
    end
  end

  assign diff = canvas_q - prod_q[CanvasW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      canvas_q <= canvas;
      stride_q <= StrideW'((canvas + CanvasW'(7)) >> 3);
      prod_q   <= ProdW'(cfg_i.cell_count) * ProdW'(cfg_i.pixel_scale);
    end
    if (cmd_i.margin_en) begin
      margin_q <= (ProdW'(canvas_q) > prod_q) ? diff[CanvasW-1:1] : '0;
    end
  end

  // ---- restoring divider, one quotient bit per step ----
  assign x0        = {scan_byte_q, 3'b000};
  assign row_rel   = (scan_row_q >= margin_q) ? scan_row_q - margin_q : '0;
  assign col_rel   = (x0 >= margin_q) ? x0 - margin_q : '0;
  assign div_trial = {div_rem_q, div_quo_q[PosW-1]};
  assign div_take  = div_trial >= {1'b0, cfg_i.pixel_scale};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      div_rem_q <= '0;
      div_quo_q <= cmd_i.div_col ? col_rel : row_rel;
    end else if (cmd_i.div_step) begin
      div_rem_q <= div_take ? ScaleW'(div_trial - {1'b0, cfg_i.pixel_scale})
                            : div_trial[ScaleW-1:0];
      div_quo_q <= {div_quo_q[PosW-2:0], div_take};
    end
  end

  // ---- row capture ----
  assign row_ok = (cfg_i.pixel_scale != '0) && ({1'b0, scan_row_q} < canvas_q)
                  && (scan_row_q >= margin_q);
  assign row_module = (div_quo_q > PosW'(255)) ? 8'hFF : div_quo_q[ModW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_in_q  <= 1'b0;
      p_valid_q <= 1'b0;
    end else begin
      if (cmd_i.row_capture) begin
        row_in_q <= row_ok && (div_quo_q < PosW'(cfg_i.region_h));
      end
      p_valid_q <= cmd_i.pix_step && px_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_capture) begin
      mrow_q <= PosW'(cfg_i.region_y0) + PosW'(row_module);
    end
  end

  // ---- pixel walk: column quotient advances one pixel at a time ----
  assign px_x   = x0 + PosW'(cmd_i.pix_idx);
  assign x_ge_m = px_x >= margin_q;
  assign col    = ColW'(cfg_i.region_x0) + ColW'(rx_q);
  assign px_ok  = row_in_q && x_ge_m && ({1'b0, px_x} < canvas_q)
                  && (rx_q < RxW'(cfg_i.region_w))
                  && (col < ColW'(cfg_i.symbol_size)) && (col < ColW'(MaxModules))
                  && (mrow_q < PosW'(cfg_i.symbol_size)) && (mrow_q < PosW'(MaxModules));
  assign raddr  = px_ok ? AddrW'(mrow_q) * AddrW'(RowWords) + AddrW'(col >> BitW) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.col_capture) begin
      rx_q  <= RxW'(div_quo_q);
      rem_q <= div_rem_q;
    end else if (cmd_i.pix_step && x_ge_m) begin
      if ({1'b0, rem_q} + 1'b1 == {1'b0, cfg_i.pixel_scale}) begin
        rx_q  <= rx_q + 1'b1;
        rem_q <= '0;
      end else begin
        rem_q <= rem_q + 1'b1;
      end
    end
    if (cmd_i.pix_step) begin
      p_bit_q <= col[BitW-1:0];
      p_pos_q <= ~cmd_i.pix_idx;
    end
    if (cmd_i.start) begin
      bits_q <= '0;
    end else if (p_valid_q && rd_q[p_bit_q]) begin
      bits_q[p_pos_q] <= 1'b1;
    end
  end

  // ---- scan position and output word ----
  assign byte_last = ({1'b0, scan_byte_q} + 1'b1) >= stride_q;
  assign row_last  = ({1'b0, scan_row_q} + 1'b1) >= canvas_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q  <= '0;
      scan_byte_q <= '0;
    end else if (cmd_i.out_load) begin
      if (byte_last) begin
        scan_byte_q <= '0;
        scan_row_q  <= row_last ? '0 : scan_row_q + 1'b1;
      end else begin
        scan_byte_q <= scan_byte_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pixel_byte_q  <= bits_q;
      canvas_row_q  <= scan_row_q;
      byte_column_q <= scan_byte_q;
      frame_end_q   <= row_last && byte_last;
    end
  end

  assign pixel_byte_o  = pixel_byte_q;
  assign canvas_row_o  = canvas_row_q;
  assign byte_column_o = byte_column_q;
  assign frame_end_o   = frame_end_q;

endmodule

FILE: rtl/qr_module_upscale_scanout.sv
// Top level of the QR module upscale scan-out block.
`timescale 1ns / 1ps

// QR module map to 1-bit canvas scan-out. A load word (opcode 0) writes 32
// module bits of one symbol row into a 177 x 6 word store and is taken
// while the block is idle, so loads stream at one word per clock when no
// emit is in progress. An emit word (opcode 1) produces the next byte of the
// square canvas in raster order, MSB leftmost, with frame_end set on the last
// byte; the scan wraps back to the frame start by itself. The next word is
// accepted only after the emit's steps: a wait behind the scale-by-cell
// product, the centering margin, a load and nine steps of the shared
// restoring divider for the pixel row, a reload and nine steps for the first
// pixel column, a capture of that column quotient, a pixel step for each bit
// of the byte on the single store read port, a drain of the registered store
// read and a load of the output register. The output register lets the next
// word be accepted while a finished byte waits on out_ready_i; a second
// finished byte holds the input until the first leaves. There is no clearing
// pass after reset; every module row the symbol covers must be loaded before
// scanning. Configuration is written over APB (registers at 4*index); the
// user must write it only while idle, which the block does not enforce, and
// it takes effect on the next byte without moving the scan position.

module qr_module_upscale_scanout (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qrus_pkg::RegAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [7:0]                    module_row_i,
  input  logic [2:0]                    word_index_i,
  input  logic [31:0]                   module_bits_i,
  // output words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    pixel_byte_o,
  output logic [8:0]                    canvas_row_o,
  output logic [5:0]                    byte_column_o,
  output logic                          frame_end_o
);
  import qrus_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  qrus_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: owns the handshakes and steps the datapath.
  qrus_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Datapath: store, geometry, divider, pixel walk and output word.
  qrus_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg),
    .module_row_i  (module_row_i),
    .word_index_i  (word_index_i),
    .module_bits_i (module_bits_i),
    .pixel_byte_o  (pixel_byte_o),
    .canvas_row_o  (canvas_row_o),
    .byte_column_o (byte_column_o),
    .frame_end_o   (frame_end_o)
  );

endmodule
